// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the fan supervisor.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on i_clk, switched off while i_rst_n is low.
`define FSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked on i_clk, also checked across reset.
`define FSS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/fss_pkg.sv =====
// Types, register map and CRC tables for the fan speed supervisor.
// No dependencies; used by fan_speed_supervisor_core.
package fss_pkg;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_LOWER_THRESHOLD = 3'd0,
        REG_UPPER_THRESHOLD = 3'd1,
        REG_ONOFF_TRIGGER   = 3'd2,
        REG_PWM_TOP         = 3'd3,
        REG_MIN_PULSES      = 3'd4,
        REG_MAX_RESTARTS    = 3'd5,
        REG_MIN_PULSE_DIFF  = 3'd6
    } t_reg_idx;

    // Word kinds on the input channel
    localparam logic ACT_PROBE   = 1'b0;
    localparam logic ACT_CONTROL = 1'b1;

    // Register reset values
    localparam logic [11:0] LOWER_THRESHOLD_RST = 12'd400;
    localparam logic [11:0] UPPER_THRESHOLD_RST = 12'd640;
    localparam logic [11:0] ONOFF_TRIGGER_RST   = 12'd480;
    localparam logic [8:0]  PWM_TOP_RST         = 9'd400;
    localparam logic [15:0] MIN_PULSES_RST      = 16'd4;
    localparam logic [3:0]  MAX_RESTARTS_RST    = 4'd10;
    localparam logic [14:0] MIN_PULSE_DIFF_RST  = 15'd25;

    // Reflected CRC-8 over the nine scratchpad bytes
    localparam logic [7:0] CRC_POLY    = 8'h8C;
    localparam int unsigned SCRATCH_W  = 72;

    typedef logic [SCRATCH_W-1:0][7:0] t_crc_cols;

    // Contribution of each message bit to the final CRC (linear, zero seed)
    function automatic t_crc_cols crc8_cols();
        t_crc_cols        cols;
        logic [SCRATCH_W-1:0] msg;
        logic [7:0]       crc;
        for (int k = 0; k < SCRATCH_W; k++) begin
            msg = '0;
            msg[k] = 1'b1;
            crc = 8'h00;
            for (int j = 0; j < SCRATCH_W / 8; j++) begin
                crc = crc ^ msg[8*j +: 8];
                for (int i = 0; i < 8; i++) begin
                    crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 8'h00);
                end
            end
            cols[k] = crc;
        end
        return cols;
    endfunction

    localparam t_crc_cols CRC_COLS = crc8_cols();

    // XOR tree over the set message bits
    function automatic logic [7:0] crc8_residue(input logic [SCRATCH_W-1:0] msg);
        logic [7:0] crc;
        crc = 8'h00;
        for (int k = 0; k < SCRATCH_W; k++) begin
            crc = crc ^ (msg[k] ? CRC_COLS[k] : 8'h00);
        end
        return crc;
    endfunction

endpackage

// ===== design/fan_speed_supervisor_core.sv =====
// Fan speed supervisor: input register, one pass of control logic, result register.
// Depends on fss_pkg.
// A word in the input register moves on to the result register once that register is free.
// Throughput: one word per cycle unless the output stalls; the mode, supply and duty state
// updates in the same cycle as the result register, so the next word sees it at once.
// Reset (synchronous, i_rst_n low): both pipeline stages empty, registers at their
// defaults, on-off mode with the supply on and duty 0.
module fan_speed_supervisor_core #(
    parameter int unsigned DUTY_SCALE_NUM = 5,
    parameter int unsigned DUTY_SCALE_DEN = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [15:0] i_pulse_count,
    input  logic [15:0] i_probe_low_pulses,
    input  logic        i_sensor_present,
    input  logic [63:0] i_scratch_low,
    input  logic [7:0]  i_scratch_high,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [8:0]  o_duty,
    output logic        o_fan_power,
    output logic        o_kicked,
    output logic        o_sensor_ok,
    output logic        o_pwm_mode,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Ramp (t - lower) * NUM / DEN as one multiply by NUM * ceil(2^SHIFT / DEN)
    localparam int unsigned DIFF_W  = 16;
    localparam int unsigned PROD_W  = DIFF_W + $clog2(DUTY_SCALE_NUM + 1);
    localparam int unsigned SHIFT   = PROD_W + $clog2(DUTY_SCALE_DEN);
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(DUTY_SCALE_DEN) - 64'd1) / 64'(DUTY_SCALE_DEN);
    localparam longint unsigned KMUL  = RECIP * 64'(DUTY_SCALE_NUM);
    localparam int unsigned K_W     = $clog2(KMUL + 64'd1);
    localparam int unsigned MUL_W   = DIFF_W + K_W;
    localparam int unsigned Q_W     = MUL_W - SHIFT;

    // configuration registers
    logic [11:0] r_lower_threshold;
    logic [11:0] r_upper_threshold;
    logic [11:0] r_onoff_trigger;
    logic [8:0]  r_pwm_top;
    logic [15:0] r_min_pulses;
    logic [3:0]  r_max_restarts;
    logic [14:0] r_min_pulse_diff;

    // state
    logic [4:0]  r_mode_count, n_mode_count;
    logic        r_power, n_power;
    logic [8:0]  r_duty, n_duty;

    // input stage
    logic        r_s1_vld;
    logic        r_s1_action;
    logic [15:0] r_s1_pulses;
    logic [15:0] r_s1_low_pulses;
    logic        r_s1_present;
    logic [63:0] r_s1_scratch_low;
    logic [7:0]  r_s1_scratch_high;

    // result stage
    logic        r_out_vld;
    logic [8:0]  r_out_duty;
    logic        r_out_power;
    logic        r_out_kicked;
    logic        r_out_ok;
    logic        r_out_pwm;

    logic        out_free;
    logic        s1_adv;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    logic signed [16:0] probe_diff;
    logic               probe_sel;
    logic [4:0]         mode_inc;
    logic               sensor_ok;
    logic signed [15:0] temp;
    logic signed [15:0] lower_ext;
    logic signed [15:0] upper_ext;
    logic signed [15:0] trigger_ext;
    logic               temp_below;
    logic               temp_at_upper;
    logic               temp_at_trigger;
    logic signed [16:0] ramp_diff;
    logic [MUL_W-1:0]   ramp_mul;
    logic [Q_W-1:0]     ramp_q;
    logic [Q_W+8:0]     ramp_q_ext;
    logic [Q_W+8:0]     top_ext;
    logic [8:0]         ramp_duty;
    logic               kick;

    // ---------------- handshake ----------------
    assign out_free    = !r_out_vld || !i_out_stall;
    assign s1_adv      = r_s1_vld && out_free;
    assign o_in_stall  = r_s1_vld && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_s1_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_action       <= i_action;
            r_s1_pulses       <= i_pulse_count;
            r_s1_low_pulses   <= i_probe_low_pulses;
            r_s1_present      <= i_sensor_present;
            r_s1_scratch_low  <= i_scratch_low;
            r_s1_scratch_high <= i_scratch_high;
        end
    end

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_threshold <= fss_pkg::LOWER_THRESHOLD_RST;
            r_upper_threshold <= fss_pkg::UPPER_THRESHOLD_RST;
            r_onoff_trigger   <= fss_pkg::ONOFF_TRIGGER_RST;
            r_pwm_top         <= fss_pkg::PWM_TOP_RST;
            r_min_pulses      <= fss_pkg::MIN_PULSES_RST;
            r_max_restarts    <= fss_pkg::MAX_RESTARTS_RST;
            r_min_pulse_diff  <= fss_pkg::MIN_PULSE_DIFF_RST;
        end else if (cfg_wr) begin
            case (fss_pkg::t_reg_idx'(cfg_idx))
                fss_pkg::REG_LOWER_THRESHOLD: r_lower_threshold <= pwdata[11:0];
                fss_pkg::REG_UPPER_THRESHOLD: r_upper_threshold <= pwdata[11:0];
                fss_pkg::REG_ONOFF_TRIGGER:   r_onoff_trigger   <= pwdata[11:0];
                fss_pkg::REG_PWM_TOP:         r_pwm_top         <= pwdata[8:0];
                fss_pkg::REG_MIN_PULSES:      r_min_pulses      <= pwdata[15:0];
                fss_pkg::REG_MAX_RESTARTS:    r_max_restarts    <= pwdata[3:0];
                fss_pkg::REG_MIN_PULSE_DIFF:  r_min_pulse_diff  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (fss_pkg::t_reg_idx'(cfg_idx))
            fss_pkg::REG_LOWER_THRESHOLD: prdata = 32'(r_lower_threshold);
            fss_pkg::REG_UPPER_THRESHOLD: prdata = 32'(r_upper_threshold);
            fss_pkg::REG_ONOFF_TRIGGER:   prdata = 32'(r_onoff_trigger);
            fss_pkg::REG_PWM_TOP:         prdata = 32'(r_pwm_top);
            fss_pkg::REG_MIN_PULSES:      prdata = 32'(r_min_pulses);
            fss_pkg::REG_MAX_RESTARTS:    prdata = 32'(r_max_restarts);
            fss_pkg::REG_MIN_PULSE_DIFF:  prdata = 32'(r_min_pulse_diff);
            default:                      prdata = 32'd0;
        endcase
    end

    // ---------------- datapath ----------------
    assign probe_diff = $signed({1'b0, r_s1_pulses}) - $signed({1'b0, r_s1_low_pulses});
    assign probe_sel  = probe_diff > $signed({2'b00, r_min_pulse_diff});
    assign mode_inc   = r_mode_count + 5'd1;

    assign sensor_ok = r_s1_present && (r_s1_scratch_low[39:32] != 8'h00) &&
                       (fss_pkg::crc8_residue({r_s1_scratch_high, r_s1_scratch_low}) == 8'h00);

    assign temp        = $signed(r_s1_scratch_low[15:0]);
    assign lower_ext   = $signed({{4{r_lower_threshold[11]}}, r_lower_threshold});
    assign upper_ext   = $signed({{4{r_upper_threshold[11]}}, r_upper_threshold});
    assign trigger_ext = $signed({{4{r_onoff_trigger[11]}}, r_onoff_trigger});

    assign temp_below      = temp < lower_ext;
    assign temp_at_upper   = temp >= upper_ext;
    assign temp_at_trigger = temp >= trigger_ext;

    // non-negative whenever the ramp is used, and below 2^16
    assign ramp_diff  = $signed({temp[15], temp}) - $signed({lower_ext[15], lower_ext});
    assign ramp_mul   = MUL_W'(ramp_diff[15:0]) * MUL_W'(KMUL);
    assign ramp_q     = ramp_mul[MUL_W-1:SHIFT];
    assign ramp_q_ext = (Q_W+9)'(ramp_q);
    assign top_ext    = (Q_W+9)'(r_pwm_top);
    assign ramp_duty  = (ramp_q_ext > top_ext) ? r_pwm_top : ramp_q_ext[8:0];

    always_comb begin
        n_mode_count = r_mode_count;
        n_power      = r_power;
        n_duty       = r_duty;
        kick         = 1'b0;
        if (r_s1_action == fss_pkg::ACT_PROBE) begin
            n_mode_count = probe_sel ? 5'd1 : 5'd0;
            n_power      = 1'b1;
            n_duty       = 9'd0;
        end else begin
            // stall check in PWM mode with the supply on
            if ((r_mode_count != 5'd0) && r_power) begin
                if (r_s1_pulses < r_min_pulses) begin
                    n_duty       = r_pwm_top;
                    n_power      = 1'b1;
                    kick         = 1'b1;
                    n_mode_count = (mode_inc > {1'b0, r_max_restarts}) ? 5'd0 : mode_inc;
                end else begin
                    n_mode_count = 5'd1;
                end
            end
            if (!sensor_ok) begin
                n_duty  = r_pwm_top;
                n_power = 1'b1;
            end else if (temp_below) begin
                n_duty  = 9'd0;
                n_power = 1'b0;
            end else if (n_mode_count != 5'd0) begin
                n_power = 1'b1;
                n_duty  = temp_at_upper ? r_pwm_top : ramp_duty;
            end else if (temp_at_trigger) begin
                n_duty  = r_pwm_top;
                n_power = 1'b1;
            end
            // on-off mode below the trigger: hold supply and duty
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_count <= 5'd0;
            r_power      <= 1'b1;
            r_duty       <= 9'd0;
        end else if (s1_adv) begin
            r_mode_count <= n_mode_count;
            r_power      <= n_power;
            r_duty       <= n_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_duty   <= n_duty;
            r_out_power  <= n_power;
            r_out_kicked <= kick;
            r_out_ok     <= (r_s1_action == fss_pkg::ACT_CONTROL) && sensor_ok;
            r_out_pwm    <= n_mode_count != 5'd0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_duty      = r_out_duty;
    assign o_fan_power = r_out_power;
    assign o_kicked    = r_out_kicked;
    assign o_sensor_ok = r_out_ok;
    assign o_pwm_mode  = r_out_pwm;

endmodule

// ===== design/fss_checker.sv =====
// Port-level checks for fan_speed_supervisor_core, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module fss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [8:0]  o_duty,
    input logic        o_fan_power,
    input logic        o_kicked,
    input logic        o_sensor_ok,
    input logic        o_pwm_mode
);

    logic        out_held;
    logic        bad_sensor;
    logic        busy;
    logic [12:0] out_word;

    assign out_held   = o_out_valid && i_out_stall;
    assign bad_sensor = o_out_valid && !o_sensor_ok;
    assign busy       = o_out_valid || o_in_stall;
    assign out_word   = {o_duty, o_fan_power, o_kicked, o_sensor_ok, o_pwm_mode};

    // hold a stalled result word
    `FSS_ASSERT(a_out_valid_hold, out_held |=> o_out_valid, "result word dropped while stalled")
    `FSS_ASSERT(a_out_data_hold, out_held |=> $stable(out_word), "stalled result word changed")

    // input stalls only behind a full, stalled result register
    `FSS_ASSERT(a_in_stall_cause, o_in_stall |-> out_held, "input stalled, result not stalled")

    // without good sensor data the supply is always on
    `FSS_ASSERT(a_bad_sensor_power, bad_sensor |-> o_fan_power, "supply off on bad sensor data")

    // reset empties both stages
    `FSS_ASSERT_RST(a_reset_empty, !i_rst_n |=> !busy, "pipeline not empty after reset")

endmodule

bind fan_speed_supervisor_core fss_checker u_fss_checker (.*);
